// File: design/rqsd_pkg.sv
// ============================================================================
// rqsd_pkg
// Shared types and codes for the record queue with search and delete.
// ============================================================================
package rqsd_pkg;

    // Width of one string field on the channels
    localparam int FIELD_W = 64;

    // Command codes
    localparam logic [2:0] CMD_ENQUEUE = 3'd0;
    localparam logic [2:0] CMD_DEQUEUE = 3'd1;
    localparam logic [2:0] CMD_SEARCH  = 3'd2;
    localparam logic [2:0] CMD_DELETE  = 3'd3;
    localparam logic [2:0] CMD_LIST    = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_DEQUEUED = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_DELETED  = 3'd6;
    localparam logic [2:0] ST_LIST     = 3'd7;

    typedef struct packed {
        logic [2:0]         command;
        logic [FIELD_W-1:0] first_name;
        logic [FIELD_W-1:0] last_name;
        logic [FIELD_W-1:0] student_id;
        logic [FIELD_W-1:0] search_key;
    } rqsd_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [FIELD_W-1:0] out_first;
        logic [FIELD_W-1:0] out_last;
        logic [FIELD_W-1:0] out_id;
        logic [3:0]         occupancy;
        logic               last_of_run;
    } rqsd_rsp_t;

    // Source of the record fields in a result
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_HOLD,
        SRC_RAM
    } rqsd_src_t;

    // Controller to datapath
    typedef struct packed {
        logic       req_load;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       rd_ahead;
        logic       wr_en;
        logic       wr_shift;
        logic       hold_load;
        logic       out_load;
        rqsd_src_t  out_src;
        logic [2:0] out_status;
        logic       out_last;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       head_adv;
    } rqsd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] command;
        logic       full;
        logic       empty;
        logic       more;
        logic       more2;
        logic       match_any;
        logic       match_id;
        logic       out_free;
    } rqsd_stat_t;

endpackage

// File: design/rqsd_chan_if.sv
// ============================================================================
// rqsd_chan_if
// Valid/ready channel carrying one payload per transfer.
// ============================================================================
interface rqsd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/record_queue_search_delete_unit.sv
// ============================================================================
// record_queue_search_delete_unit
// Bounded FIFO of name/ID records with case-blind search and ordered delete.
// ============================================================================
// The unit holds up to CAPACITY records of three short ASCII strings in a
// circular record store and works on one command at a time. Enqueue,
// dequeue, full and empty answers pass through the dispatch state into the
// result register; the unit accepts the next command in the same cycle
// that this result is first offered. Search, delete and list walk the
// queue through the single read port of the record store, one entry per
// cycle. A list offers its entries one per cycle while the result side
// keeps taking them. A delete that hits slides every entry behind the
// removed one down through the same port, one per cycle, before it answers.
// Results leave through one output register, so a stalled consumer holds
// back each answer and stalls a list walk. Strings are cut at their first
// zero byte (and at NAME_BYTES) before they are stored or compared.
// ============================================================================
module record_queue_search_delete_unit
    import rqsd_pkg::*;
#(
    parameter int CAPACITY   = 8,
    parameter int NAME_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    rqsd_chan_if.sink   request,
    rqsd_chan_if.source result
);

    rqsd_cmd_t  cmd;
    rqsd_stat_t stat;
    rqsd_req_t  req_data;
    logic       in_ready;

    assign req_data      = request.data;
    assign request.ready = in_ready;

    // Sequencer: takes a transfer only when idle, then steps the datapath
    rqsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Record store, pointers, compare and result register
    rqsd_dp #(
        .CAPACITY   (CAPACITY),
        .NAME_BYTES (NAME_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

endmodule

// File: design/rqsd_ram.sv
// ============================================================================
// rqsd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rqsd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data while no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/rqsd_ctrl.sv
// ============================================================================
// rqsd_ctrl
// Sequencer for the record queue: dispatch, walk, compact and emit.
// ============================================================================
module rqsd_ctrl
    import rqsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rqsd_stat_t stat,
    output rqsd_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_EMIT,
        S_DEQ,
        S_SRCH,
        S_DSRCH,
        S_DSHIFT,
        S_LIST
    } state_t;

    state_t     state_reg,       state_next;
    logic [2:0] emit_status_reg, emit_status_next;
    rqsd_src_t  emit_src_reg,    emit_src_next;
    logic       emit_inc_reg,    emit_inc_next;
    logic       emit_dec_reg,    emit_dec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            emit_status_reg <= ST_ADDED;
            emit_src_reg    <= SRC_ZERO;
            emit_inc_reg    <= 1'b0;
            emit_dec_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            emit_status_reg <= emit_status_next;
            emit_src_reg    <= emit_src_next;
            emit_inc_reg    <= emit_inc_next;
            emit_dec_reg    <= emit_dec_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd              = '0;
        cmd.out_src      = SRC_ZERO;
        state_next       = state_reg;
        emit_status_next = emit_status_reg;
        emit_src_next    = emit_src_reg;
        emit_inc_next    = emit_inc_reg;
        emit_dec_next    = emit_dec_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.req_load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                unique case (stat.command) inside
                    CMD_ENQUEUE:
                    begin
                        emit_inc_next = 1'b0;
                        emit_dec_next = 1'b0;
                        if (stat.full)
                        begin
                            emit_status_next = ST_FULL;
                            emit_src_next    = SRC_ZERO;
                        end
                        else
                        begin
                            // store at the rear now, count up with the result
                            cmd.wr_en        = 1'b1;
                            emit_status_next = ST_ADDED;
                            emit_src_next    = SRC_HOLD;
                            emit_inc_next    = 1'b1;
                        end
                        state_next = S_EMIT;
                    end
                    CMD_DEQUEUE, CMD_SEARCH, CMD_DELETE, CMD_LIST:
                    begin
                        if (stat.empty)
                        begin
                            emit_status_next = ST_EMPTY;
                            emit_src_next    = SRC_ZERO;
                            emit_inc_next    = 1'b0;
                            emit_dec_next    = 1'b0;
                            state_next       = S_EMIT;
                        end
                        else
                        begin
                            // fetch the front entry
                            cmd.idx_clr = 1'b1;
                            cmd.rd_en   = 1'b1;
                            unique case (stat.command)
                                CMD_DEQUEUE: state_next = S_DEQ;
                                CMD_SEARCH:  state_next = S_SRCH;
                                CMD_DELETE:  state_next = S_DSRCH;
                                default:     state_next = S_LIST;
                            endcase
                        end
                    end
                    default:
                    begin
                        // unused command: drop it
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = emit_status_reg;
                    cmd.out_src    = emit_src_reg;
                    cmd.out_last   = 1'b1;
                    cmd.cnt_inc    = emit_inc_reg;
                    cmd.cnt_dec    = emit_dec_reg;
                    state_next     = S_IDLE;
                end
            end

            S_DEQ:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_DEQUEUED;
                    cmd.out_src    = SRC_RAM;
                    cmd.out_last   = 1'b1;
                    cmd.cnt_dec    = 1'b1;
                    cmd.head_adv   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SRCH:
            begin
                if (stat.match_any)
                begin
                    // hold the matching entry until the result slot frees up
                    if (stat.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_FOUND;
                        cmd.out_src    = SRC_RAM;
                        cmd.out_last   = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.more)
                begin
                    cmd.idx_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                end
                else
                begin
                    emit_status_next = ST_NOTFOUND;
                    emit_src_next    = SRC_ZERO;
                    emit_inc_next    = 1'b0;
                    emit_dec_next    = 1'b0;
                    state_next       = S_EMIT;
                end
            end

            S_DSRCH:
            begin
                if (stat.match_id)
                begin
                    cmd.hold_load    = 1'b1;
                    emit_status_next = ST_DELETED;
                    emit_src_next    = SRC_HOLD;
                    emit_inc_next    = 1'b0;
                    emit_dec_next    = 1'b1;
                    if (stat.more)
                    begin
                        // fetch the successor to slide it down
                        cmd.rd_en    = 1'b1;
                        cmd.rd_ahead = 1'b1;
                        state_next   = S_DSHIFT;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else if (stat.more)
                begin
                    cmd.idx_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                end
                else
                begin
                    emit_status_next = ST_NOTFOUND;
                    emit_src_next    = SRC_ZERO;
                    emit_inc_next    = 1'b0;
                    emit_dec_next    = 1'b0;
                    state_next       = S_EMIT;
                end
            end

            S_DSHIFT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (stat.more2)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_ahead = 1'b1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_LIST:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_LIST;
                    cmd.out_src    = SRC_RAM;
                    cmd.out_last   = !stat.more;
                    if (stat.more)
                    begin
                        cmd.idx_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/rqsd_dp.sv
// ============================================================================
// rqsd_dp
// Datapath: record store, queue pointers, key compare and result register.
// ============================================================================
module rqsd_dp
    import rqsd_pkg::*;
#(
    parameter int CAPACITY   = 8,
    parameter int NAME_BYTES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  rqsd_req_t  req_data,
    input  rqsd_cmd_t  cmd,
    output rqsd_stat_t stat,
    rqsd_chan_if.source result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int FW = 8 * NAME_BYTES;
    localparam int RW = 3 * FW;

    // Keep bytes up to the first zero byte, at most NAME_BYTES of them
    function automatic logic [FW-1:0] clean_str(input logic [FIELD_W-1:0] v);
        logic [FW-1:0] r;
        logic          live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (v[8*b +: 8] == 8'h00)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                r[8*b +: 8] = v[8*b +: 8];
            end
        end
        return r;
    endfunction

    // Fold upper-case ASCII letters to lower case
    function automatic logic [FW-1:0] fold_str(input logic [FW-1:0] v);
        logic [FW-1:0] r;
        r = v;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (v[8*b +: 8] >= 8'h41 && v[8*b +: 8] <= 8'h5A)
            begin
                r[8*b +: 8] = v[8*b +: 8] + 8'h20;
            end
        end
        return r;
    endfunction

    function automatic logic same_str(input logic [FW-1:0] a, input logic [FW-1:0] b);
        return fold_str(a) == fold_str(b);
    endfunction

    // Physical slot of queue position k
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(k);
        if (sum >= (CW+1)'(CAPACITY))
        begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return AW'(sum);
    endfunction

    logic [AW-1:0] head_reg,    head_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [CW-1:0] idx_reg,     idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    command_reg, command_next;
    logic [FW-1:0] key_reg,     key_next;
    logic [RW-1:0] hold_reg,    hold_next;
    rqsd_rsp_t     out_data_reg, out_data_next;

    logic [CW-1:0] rd_k;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [RW-1:0] wdata;
    logic [RW-1:0] rdata;
    logic [FW-1:0] rd_first, rd_last, rd_id;
    logic [FW-1:0] hd_first, hd_last, hd_id;

    assign rd_first = rdata[3*FW-1:2*FW];
    assign rd_last  = rdata[2*FW-1:FW];
    assign rd_id    = rdata[FW-1:0];
    assign hd_first = hold_reg[3*FW-1:2*FW];
    assign hd_last  = hold_reg[2*FW-1:FW];
    assign hd_id    = hold_reg[FW-1:0];

    // Walk index
    always_comb
    begin
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign rd_k  = idx_next + CW'(cmd.rd_ahead);
    assign raddr = slot(head_reg, rd_k);
    assign waddr = cmd.wr_shift ? slot(head_reg, idx_reg) : slot(head_reg, count_reg);
    assign wdata = cmd.wr_shift ? rdata : hold_reg;

    rqsd_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Status back to the sequencer
    always_comb
    begin
        stat.command   = command_reg;
        stat.full      = (count_reg >= CW'(CAPACITY));
        stat.empty     = (count_reg == '0);
        stat.more      = ((CW+1)'(idx_reg) + (CW+1)'(1)) < (CW+1)'(count_reg);
        stat.more2     = ((CW+1)'(idx_reg) + (CW+1)'(2)) < (CW+1)'(count_reg);
        stat.match_id  = same_str(rd_id, key_reg);
        stat.match_any = same_str(rd_first, key_reg) || same_str(rd_last, key_reg)
                         || stat.match_id;
        stat.out_free  = !out_valid_reg || result.ready;
    end

    // Queue pointers
    always_comb
    begin
        head_next = head_reg;
        if (cmd.head_adv)
        begin
            head_next = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);
        end
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Request capture and held record
    always_comb
    begin
        command_next = command_reg;
        key_next     = key_reg;
        hold_next    = hold_reg;
        if (cmd.req_load)
        begin
            command_next = req_data.command;
            key_next     = clean_str(req_data.search_key);
            hold_next    = {clean_str(req_data.first_name),
                            clean_str(req_data.last_name),
                            clean_str(req_data.student_id)};
        end
        else if (cmd.hold_load)
        begin
            hold_next = rdata;
        end
    end

    // Result register
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next            = 1'b1;
            out_data_next.status      = cmd.out_status;
            out_data_next.occupancy   = 4'(count_next);
            out_data_next.last_of_run = cmd.out_last;
            case (cmd.out_src)
                SRC_HOLD:
                begin
                    out_data_next.out_first = FIELD_W'(hd_first);
                    out_data_next.out_last  = FIELD_W'(hd_last);
                    out_data_next.out_id    = FIELD_W'(hd_id);
                end
                SRC_RAM:
                begin
                    out_data_next.out_first = FIELD_W'(rd_first);
                    out_data_next.out_last  = FIELD_W'(rd_last);
                    out_data_next.out_id    = FIELD_W'(rd_id);
                end
                default:
                begin
                    out_data_next.out_first = '0;
                    out_data_next.out_last  = '0;
                    out_data_next.out_id    = '0;
                end
            endcase
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg  <= command_next;
        key_reg      <= key_next;
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

// File: design/rqsd_checker.sv
// ============================================================================
// rqsd_checker
// Port-level checks on the results of the record queue.
// ============================================================================
module rqsd_checker
    import rqsd_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic [2:0]         status,
    input logic [FIELD_W-1:0] out_first,
    input logic [FIELD_W-1:0] out_last,
    input logic [FIELD_W-1:0] out_id,
    input logic [3:0]         occupancy,
    input logic               last_of_run
);

    // full is reported only with the queue at capacity
    a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> occupancy == 4'(CAPACITY))
        else $error("full reported below capacity");

    // empty answer carries no record and zero occupancy
    a_empty_blank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |->
            occupancy == 4'd0 && out_first == '0 && out_last == '0 && out_id == '0)
        else $error("empty result not blank");

    // a miss carries no record
    a_notfound_blank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_NOTFOUND |->
            out_first == '0 && out_last == '0 && out_id == '0)
        else $error("not-found result carries a record");

    // no new command is taken while a run of results is unfinished
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last_of_run |-> !req_ready)
        else $error("input taken in the middle of a result run");

endmodule

bind record_queue_search_delete_unit rqsd_checker #(
    .CAPACITY (CAPACITY)
) u_rqsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ready   (request.ready),
    .rsp_valid   (result.valid),
    .status      (result.data.status),
    .out_first   (result.data.out_first),
    .out_last    (result.data.out_last),
    .out_id      (result.data.out_id),
    .occupancy   (result.data.occupancy),
    .last_of_run (result.data.last_of_run)
);
